// ----- src/dpr_pkg.sv -----
// Debug packet receiver package: result and group types, character codes,
// result kinds, end status codes and the hex digit decoder. No dependencies.
package dpr_pkg;

    localparam int MAX_RESULTS = 4;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;

    localparam logic [1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [1:0] KIND_TX      = 2'd1;
    localparam logic [1:0] KIND_END     = 2'd2;

    localparam logic [1:0] ST_GOOD     = 2'd0;
    localparam logic [1:0] ST_MISMATCH = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;

    localparam logic [1:0] OFFSET_SEQ_ID = 2'd3;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data_byte;
        logic [7:0] byte_index;
        logic [1:0] status;
        logic [7:0] payload_length;
        logic [1:0] payload_offset;
    } dpr_result_t;

    // Results caused by one received byte, first result in item[0]
    typedef struct packed {
        dpr_result_t [MAX_RESULTS-1:0] item;
        logic [2:0]                    count;
    } dpr_group_t;

    // Invalid digits decode to all ones (-1 modulo 256)
    function automatic logic [7:0] hex_value(input logic [7:0] c);
        logic [7:0] v;
        v = 8'hFF;
        if (c >= 8'h61 && c <= 8'h66) begin
            v = c - 8'h57;
        end else if (c >= 8'h30 && c <= 8'h39) begin
            v = c - 8'h30;
        end else if (c >= 8'h41 && c <= 8'h46) begin
            v = c - 8'h37;
        end
        return v;
    endfunction

endpackage

// ----- src/dpr_parser.sv -----
// Packet framing state machine: hunts for '$', sums the payload, checks the
// two-digit checksum and builds the group of results for each byte.
// Depends on dpr_pkg.
module dpr_parser #(
    parameter int BUFFER_BYTES = 256
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               accept,
    input  logic [7:0]         in_byte,
    output dpr_pkg::dpr_group_t grp
);
    import dpr_pkg::*;

    localparam int CW = $clog2(BUFFER_BYTES);

    typedef enum logic [1:0] {
        PH_HUNT    = 2'd0,
        PH_PAYLOAD = 2'd1,
        PH_HIGH    = 2'd2,
        PH_LOW     = 2'd3
    } phase_t;

    phase_t          phase_reg, phase_next;
    logic [7:0]      sum_reg, sum_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [7:0]      high_reg, high_next;
    logic [7:0]      seq1_reg, seq1_next;
    logic [7:0]      seq2_reg, seq2_next;
    logic            colon_reg, colon_next;

    logic [CW-1:0]   count_inc;
    logic [CW+7:0]   cnt_wide;
    logic [CW+7:0]   inc_wide;
    logic [7:0]      hex_in;
    logic [7:0]      got_sum;
    dpr_result_t     blank;

    assign count_inc = count_reg + 1'b1;
    assign cnt_wide  = {8'd0, count_reg};
    assign inc_wide  = {8'd0, count_inc};
    assign hex_in    = hex_value(in_byte);
    assign got_sum   = high_reg + hex_in;
    assign blank     = '0;

    always_comb begin
        phase_next = phase_reg;
        sum_next   = sum_reg;
        count_next = count_reg;
        high_next  = high_reg;
        seq1_next  = seq1_reg;
        seq2_next  = seq2_reg;
        colon_next = colon_reg;
        grp        = '0;
        for (int i = 0; i < MAX_RESULTS; i++) begin
            grp.item[i] = blank;
        end

        case (phase_reg)
            PH_HUNT: begin
                if (in_byte == CH_DOLLAR) begin
                    sum_next   = '0;
                    count_next = '0;
                    colon_next = 1'b0;
                    phase_next = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                if (in_byte == CH_DOLLAR) begin
                    sum_next   = '0;
                    count_next = '0;
                    colon_next = 1'b0;
                end else if (in_byte == CH_HASH) begin
                    phase_next = PH_HIGH;
                end else begin
                    grp.item[0].kind       = KIND_PAYLOAD;
                    grp.item[0].data_byte  = in_byte;
                    grp.item[0].byte_index = cnt_wide[7:0];
                    grp.count              = 3'd1;
                    sum_next   = sum_reg + in_byte;
                    count_next = count_inc;
                    if (cnt_wide == (CW+8)'(0)) begin
                        seq1_next = in_byte;
                    end else if (cnt_wide == (CW+8)'(1)) begin
                        seq2_next = in_byte;
                    end else if (cnt_wide == (CW+8)'(2)) begin
                        colon_next = (in_byte == CH_COLON);
                    end
                    if (count_inc == CW'(BUFFER_BYTES - 1)) begin
                        grp.item[1].kind           = KIND_END;
                        grp.item[1].status         = ST_OVERFLOW;
                        grp.item[1].payload_length = inc_wide[7:0];
                        grp.count                  = 3'd2;
                        phase_next                 = PH_HUNT;
                    end
                end
            end
            PH_HIGH: begin
                high_next  = {hex_in[3:0], 4'd0};
                phase_next = PH_LOW;
            end
            PH_LOW: begin
                phase_next = PH_HUNT;
                grp.item[0].kind = KIND_TX;
                if (got_sum == sum_reg) begin
                    grp.item[0].data_byte = CH_PLUS;
                    if (colon_reg && cnt_wide >= (CW+8)'(3)) begin
                        grp.item[1].kind           = KIND_TX;
                        grp.item[1].data_byte      = seq1_reg;
                        grp.item[2].kind           = KIND_TX;
                        grp.item[2].data_byte      = seq2_reg;
                        grp.item[3].kind           = KIND_END;
                        grp.item[3].status         = ST_GOOD;
                        grp.item[3].payload_length = cnt_wide[7:0];
                        grp.item[3].payload_offset = OFFSET_SEQ_ID;
                        grp.count                  = 3'd4;
                    end else begin
                        grp.item[1].kind           = KIND_END;
                        grp.item[1].status         = ST_GOOD;
                        grp.item[1].payload_length = cnt_wide[7:0];
                        grp.count                  = 3'd2;
                    end
                end else begin
                    grp.item[0].data_byte      = CH_MINUS;
                    grp.item[1].kind           = KIND_END;
                    grp.item[1].status         = ST_MISMATCH;
                    grp.item[1].payload_length = cnt_wide[7:0];
                    grp.count                  = 3'd2;
                end
            end
            default: begin
                phase_next = PH_HUNT;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HUNT;
            sum_reg   <= '0;
            count_reg <= '0;
            high_reg  <= '0;
            seq1_reg  <= '0;
            seq2_reg  <= '0;
            colon_reg <= 1'b0;
        end else if (accept) begin
            phase_reg <= phase_next;
            sum_reg   <= sum_next;
            count_reg <= count_next;
            high_reg  <= high_next;
            seq1_reg  <= seq1_next;
            seq2_reg  <= seq2_next;
            colon_reg <= colon_next;
        end
    end

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_wide <= (CW+8)'(BUFFER_BYTES - 1))
        else $error("payload count beyond buffer");

    a_hash_ends_payload: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && phase_reg == PH_PAYLOAD && in_byte == CH_HASH |=> phase_reg == PH_HIGH)
        else $error("'#' did not end payload");

    a_low_returns_hunt: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && phase_reg == PH_LOW |=> phase_reg == PH_HUNT)
        else $error("checksum byte did not close packet");
`endif

endmodule

// ----- src/dpr_serializer.sv -----
// Result buffer: a pending group register ahead of an output shift register
// that hands results out one per transaction. Depends on dpr_pkg.
module dpr_serializer (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  dpr_pkg::dpr_group_t grp,
    output logic                m_valid,
    input  logic                m_ready,
    output dpr_pkg::dpr_result_t m_result,
    output logic                m_last
);
    import dpr_pkg::*;

    dpr_group_t                    pend_reg;
    logic                          pend_valid_reg;
    dpr_result_t [MAX_RESULTS-1:0] out_reg, out_next;
    logic [2:0]                    rem_reg, rem_next;

    logic pop, out_free, move, load;

    assign m_valid  = (rem_reg != 3'd0);
    assign pop      = m_valid && m_ready;
    assign out_free = (rem_reg == 3'd0) || (rem_reg == 3'd1 && pop);
    assign move     = pend_valid_reg && out_free;
    assign s_ready  = !pend_valid_reg || move;
    assign load     = s_valid && s_ready && (grp.count != 3'd0);
    assign m_result = out_reg[0];
    assign m_last   = (rem_reg == 3'd1);

    always_comb begin
        out_next = out_reg;
        rem_next = rem_reg;
        if (move) begin
            out_next = pend_reg.item;
            rem_next = pend_reg.count;
        end else if (pop) begin
            for (int i = 0; i < MAX_RESULTS - 1; i++) begin
                out_next[i] = out_reg[i+1];
            end
            out_next[MAX_RESULTS-1] = '0;
            rem_next = rem_reg - 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_valid_reg <= 1'b0;
            rem_reg        <= 3'd0;
        end else begin
            rem_reg <= rem_next;
            if (load) begin
                pend_valid_reg <= 1'b1;
            end else if (move) begin
                pend_valid_reg <= 1'b0;
            end
        end
        out_reg <= out_next;
        if (load) begin
            pend_reg <= grp;
        end
    end

`ifndef SYNTHESIS
    a_rem_range: assert property (@(posedge aclk) disable iff (!aresetn)
        rem_reg <= 3'(MAX_RESULTS))
        else $error("result count beyond group size");

    a_pend_held: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_valid_reg && !out_free |=> pend_valid_reg && $stable(pend_reg))
        else $error("pending group lost while output busy");

    a_last_closes: assert property (@(posedge aclk) disable iff (!aresetn)
        pop && m_last && !pend_valid_reg |=> !m_valid)
        else $error("results continue after last");
`endif

endmodule

// ----- src/debug_packet_receiver.sv -----
// Debug packet receiver top level: framing state machine and result buffer.
// Depends on dpr_pkg, dpr_parser and dpr_serializer.
//
// Usage:
//   Input channel s_valid/s_ready/s_rx_byte takes one link byte per
//   transaction. Packets have the form $<payload>#<hi><lo>.
//   Result channel m_valid/m_ready carries kind, data_byte, byte_index,
//   status, payload_length, payload_offset and last. A byte causes zero to
//   four results; m_last marks the final one of each byte.
// Path: a byte's results are registered in the pending group register, then
//   moved to the output shift register, which offers the first of them.
// Throughput: one byte per cycle while bytes cause at most one result and m_ready
//   stays high; a byte that causes more than one result holds the result port
//   until the output shift register has handed all of them out.
// Reset (aresetn low, synchronous): back to hunting for '$', sums, counts and
//   sequence id cleared, buffered results dropped.
// Stall: while m_ready is low the pending group register absorbs one more
//   byte's results, then s_ready drops until results drain.
module debug_packet_receiver #(
    parameter int BUFFER_BYTES = 256
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_rx_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [1:0] m_kind,
    output logic [7:0] m_data_byte,
    output logic [7:0] m_byte_index,
    output logic [1:0] m_status,
    output logic [7:0] m_payload_length,
    output logic [1:0] m_payload_offset,
    output logic       m_last
);
    import dpr_pkg::*;

    dpr_group_t  grp;
    dpr_result_t result;
    logic        accept;

    assign accept = s_valid && s_ready;

    dpr_parser #(
        .BUFFER_BYTES(BUFFER_BYTES)
    ) u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (accept),
        .in_byte (s_rx_byte),
        .grp     (grp)
    );

    dpr_serializer u_serializer (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .grp      (grp),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_result (result),
        .m_last   (m_last)
    );

    assign m_kind           = result.kind;
    assign m_data_byte      = result.data_byte;
    assign m_byte_index     = result.byte_index;
    assign m_status         = result.status;
    assign m_payload_length = result.payload_length;
    assign m_payload_offset = result.payload_offset;

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for debug_packet_receiver: framing, checksum, sequence id,
// back-to-back, overflow and random traffic tests. Depends on dpr_pkg and receiver RTL.
module tb;
    import dpr_pkg::*;

    localparam int BUFFER_BYTES = 256;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int IDLE_PCT     = 7;

    typedef enum logic [1:0] {
        FR_HUNT    = 2'd0,
        FR_BODY    = 2'd1,
        FR_CSUM_HI = 2'd2,
        FR_CSUM_LO = 2'd3
    } frame_phase_t;

    typedef struct packed {
        dpr_result_t res;
        logic        last;
    } link_result_t;

    typedef logic [7:0] byte_q_t[$];

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    logic [7:0] s_rx_byte;
    logic       m_valid;
    logic       m_ready;
    logic [1:0] m_kind;
    logic [7:0] m_data_byte;
    logic [7:0] m_byte_index;
    logic [1:0] m_status;
    logic [7:0] m_payload_length;
    logic [1:0] m_payload_offset;
    logic       m_last;

    // Receiver model state
    frame_phase_t frame_phase = FR_HUNT;
    logic [7:0]   frame_sum   = '0;
    int           frame_len   = 0;
    logic [7:0]   csum_high   = '0;
    logic [7:0]   seq_id0     = '0;
    logic [7:0]   seq_id1     = '0;
    logic         colon_third = 1'b0;

    link_result_t due_results[$];
    int           mismatches    = 0;
    int           results_seen  = 0;
    int           counted_bytes = 0;
    int           cycles        = 0;
    bit           no_idle       = 1'b0;

    debug_packet_receiver #(
        .BUFFER_BYTES(BUFFER_BYTES)
    ) i_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_rx_byte       (s_rx_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_kind          (m_kind),
        .m_data_byte     (m_data_byte),
        .m_byte_index    (m_byte_index),
        .m_status        (m_status),
        .m_payload_length(m_payload_length),
        .m_payload_offset(m_payload_offset),
        .m_last          (m_last)
    );

    initial begin
        aclk = 1'b0;
    end

    always #6 aclk = ~aclk;

    // ---------------- model ----------------

    function automatic logic [7:0] digit_of(input logic [7:0] c);
        if (c >= "0" && c <= "9") return c - "0";
        if (c >= "a" && c <= "f") return c - "a" + 8'd10;
        if (c >= "A" && c <= "F") return c - "A" + 8'd10;
        return 8'hFF;
    endfunction

    function automatic link_result_t make_result(input logic [1:0] kind,
                                                 input logic [7:0] data,
                                                 input logic [7:0] idx,
                                                 input logic [1:0] st,
                                                 input logic [7:0] len,
                                                 input logic [1:0] off);
        link_result_t r;
        r.res.kind           = kind;
        r.res.data_byte      = data;
        r.res.byte_index     = idx;
        r.res.status         = st;
        r.res.payload_length = len;
        r.res.payload_offset = off;
        r.last               = 1'b0;
        return r;
    endfunction

    task automatic restart_frame();
        frame_sum   = '0;
        frame_len   = 0;
        colon_third = 1'b0;
    endtask

    // Works out the results one accepted link byte causes and queues them
    task automatic predict_link_byte(input logic [7:0] b);
        link_result_t grp[MAX_RESULTS];
        int           n;
        logic [7:0]   got;
        logic [1:0]   off;
        n = 0;
        if (frame_phase != FR_HUNT || b == CH_DOLLAR) counted_bytes++;
        case (frame_phase)
            FR_HUNT: begin
                if (b == CH_DOLLAR) begin
                    restart_frame();
                    frame_phase = FR_BODY;
                end
            end
            FR_BODY: begin
                if (b == CH_DOLLAR) begin
                    restart_frame();
                end else if (b == CH_HASH) begin
                    frame_phase = FR_CSUM_HI;
                end else begin
                    grp[n] = make_result(KIND_PAYLOAD, b, frame_len[7:0], '0, '0, '0);
                    n++;
                    frame_sum = frame_sum + b;
                    if (frame_len == 0) seq_id0 = b;
                    else if (frame_len == 1) seq_id1 = b;
                    else if (frame_len == 2) colon_third = (b == CH_COLON);
                    frame_len++;
                    if (frame_len >= BUFFER_BYTES - 1) begin
                        grp[n] = make_result(KIND_END, '0, '0, ST_OVERFLOW, frame_len[7:0], '0);
                        n++;
                        frame_phase = FR_HUNT;
                    end
                end
            end
            FR_CSUM_HI: begin
                csum_high   = digit_of(b) << 4;
                frame_phase = FR_CSUM_LO;
            end
            default: begin
                got = csum_high + digit_of(b);
                if (got == frame_sum) begin
                    off = '0;
                    grp[n] = make_result(KIND_TX, CH_PLUS, '0, '0, '0, '0);
                    n++;
                    if (colon_third && frame_len >= 3) begin
                        grp[n] = make_result(KIND_TX, seq_id0, '0, '0, '0, '0);
                        n++;
                        grp[n] = make_result(KIND_TX, seq_id1, '0, '0, '0, '0);
                        n++;
                        off = OFFSET_SEQ_ID;
                    end
                    grp[n] = make_result(KIND_END, '0, '0, ST_GOOD, frame_len[7:0], off);
                    n++;
                end else begin
                    grp[n] = make_result(KIND_TX, CH_MINUS, '0, '0, '0, '0);
                    n++;
                    grp[n] = make_result(KIND_END, '0, '0, ST_MISMATCH, frame_len[7:0], '0);
                    n++;
                end
                frame_phase = FR_HUNT;
            end
        endcase
        if (n > 0) grp[n-1].last = 1'b1;
        for (int i = 0; i < n; i++) due_results.push_back(grp[i]);
    endtask

    // ---------------- checking ----------------

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        // keep the log short if the block is badly broken
        if (mismatches <= 50)
            $display("mismatch at result %0d: %s got %0h expected %0h",
                     results_seen, what, got, want);
    endtask

    task automatic check_field(input string what, input int got, input int want);
        if (got != want) report_mismatch(what, got, want);
    endtask

    always @(posedge aclk) begin : result_check
        link_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (due_results.size() == 0) begin
                report_mismatch("unexpected result, kind", m_kind, 0);
            end else begin
                want = due_results.pop_front();
                check_field("kind", m_kind, want.res.kind);
                check_field("data_byte", m_data_byte, want.res.data_byte);
                check_field("byte_index", m_byte_index, want.res.byte_index);
                check_field("status", m_status, want.res.status);
                check_field("payload_length", m_payload_length, want.res.payload_length);
                check_field("payload_offset", m_payload_offset, want.res.payload_offset);
                check_field("last", m_last, want.last);
            end
            results_seen++;
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, due_results.size());
            $display("FAIL");
            $finish;
        end
    end

    // Result side back-pressure
    always @(negedge aclk) begin
        m_ready = no_idle || ($urandom_range(99) >= IDLE_PCT);
    end

    // ---------------- stimulus helpers ----------------

    task automatic send_byte(input logic [7:0] b);
        @(negedge aclk);
        if (!no_idle) begin
            while ($urandom_range(99) < IDLE_PCT) begin
                s_valid = 1'b0;
                @(negedge aclk);
            end
        end
        s_valid   = 1'b1;
        s_rx_byte = b;
        do @(posedge aclk); while (!s_ready);
        predict_link_byte(b);
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] nib, input bit upper);
        if (nib < 4'd10) return "0" + nib;
        return (upper ? "A" : "a") + nib - 8'd10;
    endfunction

    function automatic logic [7:0] body_checksum(input byte_q_t body);
        logic [7:0] s;
        s = '0;
        foreach (body[i]) s = s + body[i];
        return s;
    endfunction

    function automatic byte_q_t text_body(input string s);
        byte_q_t q;
        for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
        return q;
    endfunction

    // Payload bytes never frame characters, so the packet stays intact
    function automatic byte_q_t random_body(input int len);
        byte_q_t    q;
        logic [7:0] b;
        for (int i = 0; i < len; i++) begin
            b = 8'($urandom);
            if (b == CH_DOLLAR || b == CH_HASH) b = b ^ 8'h80;
            q.push_back(b);
        end
        return q;
    endfunction

    task automatic send_frame(input byte_q_t body, input logic [7:0] hi, input logic [7:0] lo);
        send_byte(CH_DOLLAR);
        foreach (body[i]) send_byte(body[i]);
        send_byte(CH_HASH);
        send_byte(hi);
        send_byte(lo);
    endtask

    task automatic send_good_frame(input byte_q_t body, input bit upper);
        logic [7:0] s;
        s = body_checksum(body);
        send_frame(body, hex_char(s[7:4], upper), hex_char(s[3:0], upper));
    endtask

    // ---------------- tests ----------------

    task automatic test_framing();
        // noise while hunting is ignored
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(CH_HASH);
        send_byte(CH_COLON);
        send_byte(8'h55);
        send_byte(8'hAA);
        send_good_frame(text_body(""), 1'b0);
        // '$' inside the payload restarts the packet
        send_byte(CH_DOLLAR);
        send_byte("x");
        send_byte("y");
        send_good_frame(text_body("ab"), 1'b0);
    endtask

    task automatic test_checksum();
        byte_q_t body;
        // invalid digits give F0 + FF = EF
        send_frame(text_body(""), "z", "z");
        body.push_back(8'hEF);
        send_frame(body, "z", "z");
        send_frame(body, CH_HASH, CH_DOLLAR);
        send_good_frame(text_body("g?"), 1'b1);
        body = text_body("<");
        send_frame(body, "3", "d");
    endtask

    task automatic test_sequence_id();
        send_good_frame(text_body("12:m"), 1'b0);
        send_good_frame(text_body("ab:"), 1'b1);
        // short packets after a colon packet must not echo
        send_good_frame(text_body("ab"), 1'b0);
        send_good_frame(text_body("a:"), 1'b0);
        send_frame(text_body("07:"), "0", "0");
    endtask

    task automatic test_back_to_back();
        no_idle = 1'b1;
        for (int i = 0; i < 3; i++) begin
            send_good_frame(text_body("9z:qT"), i[0]);
            send_good_frame(text_body(""), 1'b0);
            send_frame(random_body(2), 8'h00, 8'hFF);
        end
        no_idle = 1'b0;
    endtask

    task automatic test_overflow();
        // a packet that runs into the buffer limit, then a normal one
        send_frame(random_body(BUFFER_BYTES - 1), "0", "0");
        send_good_frame(text_body("ok:"), 1'b0);
    endtask

    task automatic test_random_traffic();
        int         pick;
        int         len;
        byte_q_t    body;
        logic [7:0] s;
        while (counted_bytes < 440) begin
            pick = $urandom_range(99);
            if (pick < 70) begin
                len  = ($urandom_range(9) == 0) ? $urandom_range(3, 30) : $urandom_range(0, 6);
                body = random_body(len);
                if (len >= 3 && $urandom_range(2) == 0) body[2] = CH_COLON;
                case ($urandom_range(9))
                    0: send_frame(body, 8'($urandom), 8'($urandom));
                    1: begin
                        s = body_checksum(body) + 8'd1;
                        send_frame(body, hex_char(s[7:4], 1'b0), hex_char(s[3:0], 1'b1));
                    end
                    default: send_good_frame(body, 1'($urandom_range(1)));
                endcase
            end else if (pick < 85) begin
                // broken packet: cut short, or a lone checksum digit
                body = random_body($urandom_range(0, 5));
                send_byte(CH_DOLLAR);
                foreach (body[i]) send_byte(body[i]);
                if ($urandom_range(1)) begin
                    send_byte(CH_HASH);
                    send_byte(8'($urandom));
                end
            end else begin
                len = $urandom_range(1, 4);
                for (int i = 0; i < len; i++) send_byte(8'($urandom));
            end
        end
    endtask

    initial begin
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_rx_byte = '0;
        m_ready   = 1'b0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_framing();
        test_checksum();
        test_sequence_id();
        test_back_to_back();
        test_overflow();
        test_random_traffic();

        @(negedge aclk);
        s_valid = 1'b0;
        while (due_results.size() != 0) @(posedge aclk);
        repeat (16) @(posedge aclk);

        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
